[rtl/sorted_table_toggle_insert_delete_macros.svh]
// Assertion macros shared by the checker of the sorted table block.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef SORTED_TABLE_TOGGLE_INSERT_DELETE_MACROS_SVH
`define SORTED_TABLE_TOGGLE_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define STT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted table check failed");

// Next-cycle implication, disabled while reset is held
`define STT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted table check failed");

`endif

[rtl/stt_pkg.sv]
// Package for the sorted table block: command and status codes, transaction types.
// No dependencies.
package stt_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DELETED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_APPENDED = 3'd2,
    ST_FULL     = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_READ_OOR = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] value;
    logic [7:0]         read_index;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         position;
    logic signed [31:0] read_value;
    logic [8:0]         entry_count;
  } out_t;

endpackage

[rtl/sorted_table_toggle_insert_delete.sv]
// Sorted table of signed 32-bit values with clear, append, toggle and read commands.
// Uses stt_pkg for codes and transaction types; holds the table in one local memory.
//
// One transaction is taken at a time; in_stall stays high until its result is
// registered. Clear and append go straight to the result; a read first waits
// for the table read. A toggle first runs a midpoint binary search, each probe
// a read, then a compare, and closes a miss once the range is empty. With n
// entries held, a hit then moves the n-1-p entries after position p down; a
// miss on a full table reports full, and any other miss scans all n entries from the
// start, placing the value before the first entry not less than it and carrying
// the rest up. The single table memory has one read and one write per cycle and
// a registered read port. The table contents are undefined after reset; only the
// count is cleared, so no clearing pass is needed.
module sorted_table_toggle_insert_delete
  import stt_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SRCH_RD  = 7'b0000010,
    S_SRCH_CMP = 7'b0000100,
    S_DELETE   = 7'b0001000,
    S_INSERT   = 7'b0010000,
    S_READ     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  // Table storage and its registered read port
  logic signed [31:0] table_mem [TABLE_DEPTH];
  logic signed [31:0] rd_data_r;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic signed [31:0] mem_wr_data;

  // Control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pend_r, pend_nxt;
  logic               placed_r, placed_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working payload
  logic signed [31:0] value_r, value_nxt;
  logic signed [SW-1:0] lo_r, lo_nxt;
  logic signed [SW-1:0] hi_r, hi_nxt;
  logic signed [SW-1:0] mid_w;
  logic [AW-1:0]      mid_r, mid_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]      pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]      at_r, at_nxt;
  logic signed [31:0] carry_r, carry_nxt;
  out_t               res_r, res_nxt;
  out_t               out_data_r;
  logic               out_load;
  logic               issue;

  function automatic out_t make_res(status_t st, logic [7:0] pos,
                                    logic signed [31:0] rval, logic [8:0] cnt);
    out_t r;
    r.status      = st;
    r.position    = pos;
    r.read_value  = rval;
    r.entry_count = cnt;
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign issue     = (rd_idx_r < count_r);
  assign mid_w     = lo_r + ((hi_r - lo_r) >>> 1);

  // Sequence each command through the table memory
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pend_nxt     = pend_r;
    placed_nxt   = placed_r;
    value_nxt    = value_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    rd_idx_nxt   = rd_idx_r;
    pend_idx_nxt = pend_idx_r;
    at_nxt       = at_r;
    carry_nxt    = carry_r;
    res_nxt      = res_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = rd_idx_r[AW-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = pend_idx_r;
    mem_wr_data  = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt = in_data.value;
          case (in_data.command)
            CMD_CLEAR: begin
              count_nxt = '0;
              res_nxt   = make_res(ST_APPENDED, 8'd0, 32'sd0, 9'd0);
              state_nxt = S_DONE;
            end
            CMD_APPEND: begin
              if (count_r == DEPTH_C) begin
                res_nxt = make_res(ST_FULL, 8'd0, 32'sd0, 9'(count_r));
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count_r[AW-1:0];
                mem_wr_data = in_data.value;
                count_nxt   = count_r + CNT_W'(1);
                res_nxt     = make_res(ST_APPENDED, 8'(count_r), 32'sd0,
                                       9'(count_r + CNT_W'(1)));
              end
              state_nxt = S_DONE;
            end
            CMD_TOGGLE: begin
              lo_nxt    = '0;
              hi_nxt    = SW'(count_r) - SW'(1);
              state_nxt = S_SRCH_RD;
            end
            CMD_READ: begin
              if (32'(in_data.read_index) < 32'(count_r)) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(in_data.read_index);
                state_nxt   = S_READ;
              end else begin
                res_nxt   = make_res(ST_READ_OOR, 8'd0, 32'sd0, 9'(count_r));
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Probe the midpoint, or stop when the range is empty
      S_SRCH_RD: begin
        if (lo_r > hi_r) begin
          if (count_r == DEPTH_C) begin
            res_nxt   = make_res(ST_FULL, 8'd0, 32'sd0, 9'(count_r));
            state_nxt = S_DONE;
          end else begin
            rd_idx_nxt = '0;
            pend_nxt   = 1'b0;
            placed_nxt = 1'b0;
            state_nxt  = S_INSERT;
          end
        end else begin
          mid_nxt     = mid_w[AW-1:0];
          mem_rd_en   = 1'b1;
          mem_rd_addr = mid_w[AW-1:0];
          state_nxt   = S_SRCH_CMP;
        end
      end

      // Narrow the range, or start the shift down on a hit
      S_SRCH_CMP: begin
        if (rd_data_r == value_r) begin
          at_nxt     = mid_r;
          rd_idx_nxt = CNT_W'(mid_r) + CNT_W'(1);
          pend_nxt   = 1'b0;
          state_nxt  = S_DELETE;
        end else begin
          if (rd_data_r < value_r) begin
            lo_nxt = SW'(mid_r) + SW'(1);
          end else begin
            hi_nxt = SW'(mid_r) - SW'(1);
          end
          state_nxt = S_SRCH_RD;
        end
      end

      // Move each later entry down by one
      S_DELETE: begin
        if (issue) begin
          mem_rd_en    = 1'b1;
          pend_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
        end
        pend_nxt = issue;
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pend_idx_r - AW'(1);
          mem_wr_data = rd_data_r;
        end
        if (!issue && !pend_r) begin
          count_nxt = count_r - CNT_W'(1);
          res_nxt   = make_res(ST_DELETED, 8'(at_r), 32'sd0,
                               9'(count_r - CNT_W'(1)));
          state_nxt = S_DONE;
        end
      end

      // Scan from the start, drop the value in place and carry the rest up
      S_INSERT: begin
        if (issue) begin
          mem_rd_en    = 1'b1;
          pend_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
        end
        pend_nxt = issue;
        if (pend_r) begin
          if (placed_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = carry_r;
            carry_nxt   = rd_data_r;
          end else if (rd_data_r >= value_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = value_r;
            carry_nxt   = rd_data_r;
            placed_nxt  = 1'b1;
            at_nxt      = pend_idx_r;
          end
        end
        if (!issue && !pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = count_r[AW-1:0];
          mem_wr_data = placed_r ? carry_r : value_r;
          count_nxt   = count_r + CNT_W'(1);
          res_nxt     = make_res(ST_INSERTED,
                                 placed_r ? 8'(at_r) : 8'(count_r), 32'sd0,
                                 9'(count_r + CNT_W'(1)));
          state_nxt   = S_DONE;
        end
      end

      S_READ: begin
        res_nxt   = make_res(ST_READ_OK, 8'd0, rd_data_r, 9'(count_r));
        state_nxt = S_DONE;
      end

      // Hold the result until the output register is free
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      placed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    at_r       <= at_nxt;
    carry_r    <= carry_nxt;
    res_r      <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // Table memory write port
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      table_mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  // Table memory read port, registered
  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_data_r <= table_mem[mem_rd_addr];
    end
  end

endmodule

[rtl/stt_checker.sv]
// Port-level checker for the sorted table block, bound to its top level.
// Depends on stt_pkg and the assertion macros header.
`include "sorted_table_toggle_insert_delete_macros.svh"

module stt_checker
  import stt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result transaction holds
  `STT_ASSERT_NEXT(a_out_hold, rst_n && out_valid && out_stall, out_valid && $stable(out_data))

  // One transaction at a time: the block turns busy after each accept
  `STT_ASSERT_NEXT(a_busy_after_accept, rst_n && in_valid && !in_stall, in_stall)

  // Only a successful read carries table data
  `STT_ASSERT_NOW(a_rval_zero, out_valid && out_data.status != ST_READ_OK, out_data.read_value == 32'sd0)

  // Refused (full) and read results report position zero
  `STT_ASSERT_NOW(a_pos_zero, out_valid && (out_data.status == ST_FULL || out_data.status == ST_READ_OK || out_data.status == ST_READ_OOR), out_data.position == 8'd0)

endmodule

bind sorted_table_toggle_insert_delete stt_checker u_stt_checker (.*);
